### rtl/brf_pkg.sv
package brf_pkg;

	localparam int DEPTH  = 64;
	localparam int PTR_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	localparam int DATA_W = 8;
	localparam int LEN_W  = 7;
	localparam int SIZE_W = 7;
	localparam int AVL_W  = 7;

	localparam int APB_DW = 32;
	localparam int APB_AW = 3;

	// register word index
	localparam logic REG_SIZE = 1'b0;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_READ  = 1'b1;

	typedef enum logic [2:0] {
		ST_WRITTEN = 3'd0,
		ST_DROPPED = 3'd1,
		ST_READ    = 3'd2,
		ST_EMPTY   = 3'd3,
		ST_REJECT  = 3'd4
	} status_t;

	typedef struct packed {
		logic write;
		logic reject;
		logic start;
		logic read;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
		logic too_long;
		logic zero_len;
		logic last_byte;
	} dp_sts_t;

endpackage

### rtl/brf_if.sv
interface brf_in_if;
	import brf_pkg::*;

	logic               valid;
	logic               ready;
	logic               mode;
	logic [DATA_W-1:0]  write_data;
	logic [LEN_W-1:0]   read_count;

	modport source (output valid, output mode, output write_data, output read_count,
		input ready);
	modport sink (input valid, input mode, input write_data, input read_count,
		output ready);
endinterface

interface brf_out_if;
	import brf_pkg::*;

	logic               valid;
	logic               ready;
	logic [DATA_W-1:0]  read_data;
	status_t            status;
	logic               last;
	logic [AVL_W-1:0]   bytes_available;
	logic               is_empty;
	logic               is_full;

	modport source (output valid, output read_data, output status, output last,
		output bytes_available, output is_empty, output is_full, input ready);
	modport sink (input valid, input read_data, input status, input last,
		input bytes_available, input is_empty, input is_full, output ready);
endinterface

### rtl/brf_ctrl.sv
module brf_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_mode,
	output logic            in_ready,
	input  brf_pkg::dp_sts_t sts,
	output brf_pkg::dp_cmd_t cmd
);
	import brf_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_BURST
	} state_t;

	state_t state_q;

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = sts.out_free;
				if (in_valid && sts.out_free) begin
					if (in_mode == MODE_WRITE) begin
						cmd.write = 1'b1;
					end else if (sts.too_long) begin
						cmd.reject = 1'b1;
					end else if (!sts.zero_len) begin
						cmd.start = 1'b1;
					end
				end
			end
			S_BURST: begin
				cmd.read = sts.out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.start) state_q <= S_BURST;
				end
				S_BURST: begin
					// leave after the final byte of the burst goes out
					if (cmd.read && sts.last_byte) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_no_accept_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BURST) |-> !in_ready)
		else $error("input accepted during burst");

	a_start_enters_burst: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> (state_q == S_BURST))
		else $error("burst start did not enter burst state");

	a_no_read_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !cmd.read)
		else $error("byte read outside a burst");

endmodule

### rtl/brf_datapath.sv
module brf_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr,
	input  logic [brf_pkg::SIZE_W-1:0]   cfg_value,
	output logic [brf_pkg::SIZE_W-1:0]   cfg_size,
	input  logic [brf_pkg::DATA_W-1:0]   write_data,
	input  logic [brf_pkg::LEN_W-1:0]    read_count,
	input  brf_pkg::dp_cmd_t             cmd,
	output brf_pkg::dp_sts_t             sts,
	brf_out_if.source                    out_ch
);
	import brf_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];

	logic [PTR_W-1:0]  wp_q, rp_q;
	logic              empty_q, full_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SIZE_W-1:0] size_q;
	logic [LEN_W-1:0]  rem_q;

	logic              out_valid_q;
	logic [DATA_W-1:0] out_data_q;
	status_t           out_status_q;
	logic              out_last_q;
	logic [AVL_W-1:0]  out_avail_q;
	logic              out_empty_q, out_full_q;

	logic              can_write, can_read, do_write, do_read, load;
	logic [PTR_W-1:0]  wp_adv, rp_adv;
	logic [PTR_W-1:0]  wp_n, rp_n;
	logic              empty_n, full_n;
	logic [CNT_W-1:0]  cnt_n;
	logic [SIZE_W-1:0] size_clamped;
	status_t           status_n;

	function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p,
		input logic [SIZE_W-1:0] sz);
		logic [SIZE_W:0] nx;
		nx = (SIZE_W + 1)'(p) + (SIZE_W + 1)'(1);
		return (nx >= (SIZE_W + 1)'(sz)) ? '0 : nx[PTR_W-1:0];
	endfunction

	assign can_write = (wp_q != rp_q) || empty_q;
	assign can_read  = (wp_q != rp_q) || full_q;
	assign do_write  = cmd.write && can_write;
	assign do_read   = cmd.read && can_read;
	assign load      = cmd.write || cmd.reject || cmd.read;
	assign wp_adv    = adv(wp_q, size_q);
	assign rp_adv    = adv(rp_q, size_q);

	always_comb begin
		if (cfg_value == '0) begin
			size_clamped = SIZE_W'(1);
		end else if (cfg_value > SIZE_W'(DEPTH)) begin
			size_clamped = SIZE_W'(DEPTH);
		end else begin
			size_clamped = cfg_value;
		end
	end

	always_comb begin
		wp_n     = wp_q;
		rp_n     = rp_q;
		empty_n  = empty_q;
		full_n   = full_q;
		cnt_n    = cnt_q;
		status_n = ST_REJECT;
		if (cmd.write) begin
			status_n = ST_DROPPED;
			if (can_write) begin
				status_n = ST_WRITTEN;
				wp_n     = wp_adv;
				full_n   = (wp_adv == rp_q);
				empty_n  = 1'b0;
				cnt_n    = cnt_q + CNT_W'(1);
			end
		end else if (cmd.read) begin
			status_n = ST_EMPTY;
			if (can_read) begin
				status_n = ST_READ;
				rp_n     = rp_adv;
				empty_n  = (rp_adv == wp_q);
				full_n   = 1'b0;
				cnt_n    = cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			rp_q        <= '0;
			empty_q     <= 1'b1;
			full_q      <= 1'b0;
			cnt_q       <= '0;
			size_q      <= SIZE_W'(DEPTH);
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				// new size: drop everything stored
				size_q  <= size_clamped;
				wp_q    <= '0;
				rp_q    <= '0;
				empty_q <= 1'b1;
				full_q  <= 1'b0;
				cnt_q   <= '0;
			end else begin
				wp_q    <= wp_n;
				rp_q    <= rp_n;
				empty_q <= empty_n;
				full_q  <= full_n;
				cnt_q   <= cnt_n;
			end
			if (cmd.start) begin
				rem_q <= read_count;
			end else if (cmd.read) begin
				rem_q <= rem_q - LEN_W'(1);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_write) mem[wp_q] <= write_data;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q   <= do_read ? mem[rp_q] : '0;
			out_status_q <= status_n;
			out_last_q   <= cmd.read ? sts.last_byte : 1'b1;
			out_avail_q  <= AVL_W'(cnt_n);
			out_empty_q  <= empty_n;
			out_full_q   <= full_n;
		end
	end

	assign sts.out_free  = !out_valid_q || out_ch.ready;
	assign sts.too_long  = read_count > LEN_W'(size_q);
	assign sts.zero_len  = (read_count == '0);
	assign sts.last_byte = (rem_q == LEN_W'(1));

	assign cfg_size = size_q;

	assign out_ch.valid           = out_valid_q;
	assign out_ch.read_data       = out_data_q;
	assign out_ch.status          = out_status_q;
	assign out_ch.last            = out_last_q;
	assign out_ch.bytes_available = out_avail_q;
	assign out_ch.is_empty        = out_empty_q;
	assign out_ch.is_full         = out_full_q;

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(empty_q && full_q))
		else $error("ring both empty and full");

	a_empty_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		empty_q == (cnt_q == '0))
		else $error("empty flag disagrees with byte count");

	a_full_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		full_q == (CNT_W'(size_q) == cnt_q))
		else $error("full flag disagrees with byte count");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ch.ready) |-> !load)
		else $error("output word overwritten while stalled");

endmodule

### rtl/byte_ring_fifo.sv
// Byte FIFO on a ring store of 64 slots, of which the first size_in_use are used.
// Input channel in_ch: mode 0 writes write_data (dropped with status 1 when full);
// mode 1 reads read_count bytes. A zero-length read gives no word; a read longer
// than size_in_use gives one reject word. A read of an empty ring gives data 0.
// Output channel out_ch: one word per result with status, last, bytes_available,
// is_empty and is_full as they stand after that result's action.
// A write or reject result is in the output register the cycle after its input word
// is accepted, so writes can follow one per cycle while out_ch takes each word. A
// burst of N bytes first registers its count on acceptance, then sends one byte per
// cycle while out_ch does not stall, from the single read port of the store, each
// byte registered in the output register. No new input word is taken until the
// burst's last byte is in the output register.
// Reset empties the ring and sets size_in_use to 64. Writing size_in_use (APB,
// byte address 0) clamps it to 1..64 and empties the ring.
// When out_ch stalls, the output register holds its word and in_ch ready drops
// until that word is taken; the buffer loses nothing.
module byte_ring_fifo (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [brf_pkg::APB_AW-1:0]   paddr,
	input  logic [brf_pkg::APB_DW-1:0]   pwdata,
	output logic [brf_pkg::APB_DW-1:0]   prdata,
	output logic                         pready,
	brf_in_if.sink                       in_ch,
	brf_out_if.source                    out_ch
);
	import brf_pkg::*;

	dp_cmd_t           cmd;
	dp_sts_t           sts;
	logic              cfg_wr;
	logic              reg_hit;
	logic [SIZE_W-1:0] cfg_size;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[APB_AW-1] == REG_SIZE);
	assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
	assign prdata  = reg_hit ? APB_DW'(cfg_size) : '0;

	brf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_mode  (in_ch.mode),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	brf_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr     (cfg_wr),
		.cfg_value  (pwdata[SIZE_W-1:0]),
		.cfg_size   (cfg_size),
		.write_data (in_ch.write_data),
		.read_count (in_ch.read_count),
		.cmd        (cmd),
		.sts        (sts),
		.out_ch     (out_ch)
	);

endmodule

### sim/tb_byte_ring_fifo.sv
module tb_byte_ring_fifo;
	timeunit 1ns;
	timeprecision 1ps;

	import brf_pkg::*;

	localparam int unsigned IDLE_PCT    = 21;
	localparam int unsigned RANDOM_SIZE = 0;

	typedef struct {
		logic [DATA_W-1:0] data;
		status_t           status;
		logic              last;
		logic [AVL_W-1:0]  avail;
		logic              empty;
		logic              full;
	} fifo_word_t;

	typedef enum {DO_WORD, DO_SIZE} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		logic              mode;
		logic [DATA_W-1:0] wdata;
		logic [LEN_W-1:0]  cnt;
		logic [31:0]       size;
		bit                pinned;
		fifo_word_t        pin;
	} row_t;

	typedef struct {
		int unsigned size;
		int unsigned items;
		int unsigned write_pct;
		bit          fill;
		bit          calm;
	} phase_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	brf_in_if  in_ch();
	brf_out_if out_ch();

	byte_ring_fifo u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

	// ring predictor state
	logic [DATA_W-1:0] ring_mem [DEPTH];
	int unsigned rd_ptr;
	int unsigned wr_ptr;
	int unsigned ring_size;
	bit ring_empty;
	bit ring_full;

	fifo_word_t expected_words[$];
	int mismatches = 0;
	bit calm = 1'b0;

	row_t plan[$];
	phase_t phases[$];

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int unsigned ring_level();
		if (ring_full)
			return ring_size;
		if (wr_ptr >= rd_ptr)
			return wr_ptr - rd_ptr;
		return ring_size - (rd_ptr - wr_ptr);
	endfunction

	function automatic int unsigned ring_next(int unsigned p);
		return (p + 1 >= ring_size) ? 0 : p + 1;
	endfunction

	function automatic void ring_resize(logic [31:0] v);
		int unsigned s;
		s = v[6:0];
		if (s < 1)
			s = 1;
		if (s > DEPTH)
			s = DEPTH;
		ring_size = s;
		rd_ptr = 0;
		wr_ptr = 0;
		ring_empty = 1'b1;
		ring_full = 1'b0;
	endfunction

	function automatic void post_word(logic [DATA_W-1:0] d, status_t st, logic last);
		fifo_word_t w;
		w.data = d;
		w.status = st;
		w.last = last;
		w.avail = AVL_W'(ring_level());
		w.empty = ring_empty;
		w.full = ring_full;
		expected_words.push_back(w);
	endfunction

	function automatic void ring_step(logic mode, logic [DATA_W-1:0] wdata,
			logic [LEN_W-1:0] cnt);
		logic [DATA_W-1:0] d;
		if (mode == MODE_WRITE) begin
			if (wr_ptr != rd_ptr || ring_empty) begin
				ring_mem[wr_ptr] = wdata;
				wr_ptr = ring_next(wr_ptr);
				if (wr_ptr == rd_ptr)
					ring_full = 1'b1;
				ring_empty = 1'b0;
				post_word('0, ST_WRITTEN, 1'b1);
			end else begin
				post_word('0, ST_DROPPED, 1'b1);
			end
			return;
		end
		if (cnt > ring_size) begin
			post_word('0, ST_REJECT, 1'b1);
			return;
		end
		for (int unsigned i = 0; i < cnt; i++) begin
			if (wr_ptr != rd_ptr || ring_full) begin
				d = ring_mem[rd_ptr];
				rd_ptr = ring_next(rd_ptr);
				if (wr_ptr == rd_ptr)
					ring_empty = 1'b1;
				ring_full = 1'b0;
				post_word(d, ST_READ, i + 1 == cnt);
			end else begin
				post_word('0, ST_EMPTY, i + 1 == cnt);
			end
		end
	endfunction

	function automatic row_t word_row(logic mode, logic [DATA_W-1:0] wdata,
			logic [LEN_W-1:0] cnt);
		row_t r;
		r.kind = DO_WORD;
		r.mode = mode;
		r.wdata = wdata;
		r.cnt = cnt;
		r.size = '0;
		r.pinned = 1'b0;
		r.pin = '{'0, ST_WRITTEN, 1'b0, '0, 1'b0, 1'b0};
		return r;
	endfunction

	function automatic row_t pinned_row(logic mode, logic [DATA_W-1:0] wdata,
			logic [LEN_W-1:0] cnt, logic [DATA_W-1:0] d, status_t st,
			logic [AVL_W-1:0] avail, logic empty, logic full);
		row_t r;
		r = word_row(mode, wdata, cnt);
		r.pinned = 1'b1;
		r.pin = '{d, st, 1'b1, avail, empty, full};
		return r;
	endfunction

	function automatic row_t size_row(logic [31:0] v);
		row_t r;
		r = word_row(MODE_WRITE, '0, '0);
		r.kind = DO_SIZE;
		r.size = v;
		return r;
	endfunction

	function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t mismatch %s: expected %0h actual %0h", $time, field, want, got);
			mismatches++;
		end
	endfunction

	task automatic send_word(logic mode, logic [DATA_W-1:0] wdata, logic [LEN_W-1:0] cnt,
			bit pinned, fifo_word_t pin);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.mode <= mode;
		in_ch.write_data <= wdata;
		in_ch.read_count <= cnt;
		do
			@(posedge clk);
		while (!in_ch.ready);
		ring_step(mode, wdata, cnt);
		// replace the prediction with the literal one
		if (pinned) begin
			void'(expected_words.pop_back());
			expected_words.push_back(pin);
		end
	endtask

	// wait out every word still owed, then a zero-length read that may be in flight
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_ring_size(logic [31:0] v);
		drain();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'(REG_SIZE) << 2;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		ring_resize(v);
	endtask

	task automatic send_random_read(int unsigned sz);
		int unsigned r;
		int unsigned cnt;
		fifo_word_t none;
		none = '{'0, ST_WRITTEN, 1'b0, '0, 1'b0, 1'b0};
		r = $urandom_range(99);
		if (r < 6)
			cnt = 0;
		else if (r < 16 && sz < DEPTH)
			cnt = $urandom_range(DEPTH, sz + 1);
		else if (r < 26)
			cnt = sz;
		else
			cnt = $urandom_range(sz < 8 ? sz : 8, 1);
		send_word(MODE_READ, '0, LEN_W'(cnt), 1'b0, none);
	endtask

	always @(posedge clk)
		out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);

	always @(posedge clk) begin
		fifo_word_t want;
		if (out_ch.valid && out_ch.ready) begin
			if (expected_words.size() == 0) begin
				$display("%0t unexpected word: expected none actual data %0h status %0d",
					$time, out_ch.read_data, out_ch.status);
				mismatches++;
			end else begin
				want = expected_words.pop_front();
				check_field("read_data", 8'(want.data), 8'(out_ch.read_data));
				check_field("status", 8'(want.status), 8'(out_ch.status));
				check_field("last", 8'(want.last), 8'(out_ch.last));
				check_field("bytes_available", 8'(want.avail),
					8'(out_ch.bytes_available));
				check_field("is_empty", 8'(want.empty), 8'(out_ch.is_empty));
				check_field("is_full", 8'(want.full), 8'(out_ch.is_full));
			end
		end
	end

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int unsigned sz;
		fifo_word_t none;
		none = '{'0, ST_WRITTEN, 1'b0, '0, 1'b0, 1'b0};
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.mode = MODE_WRITE;
		in_ch.write_data = '0;
		in_ch.read_count = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		ring_resize(DEPTH);

		plan = '{
			pinned_row(MODE_READ, 8'h00, 7'd1, 8'h00, ST_EMPTY, 7'd0, 1'b1, 1'b0),
			word_row(MODE_READ, 8'h00, 7'd0),
			pinned_row(MODE_WRITE, 8'hFF, 7'd0, 8'h00, ST_WRITTEN, 7'd1, 1'b0, 1'b0),
			pinned_row(MODE_WRITE, 8'h00, 7'd0, 8'h00, ST_WRITTEN, 7'd2, 1'b0, 1'b0),
			word_row(MODE_READ, 8'h00, 7'd64),
			size_row(32'd0),
			pinned_row(MODE_WRITE, 8'hA5, 7'd0, 8'h00, ST_WRITTEN, 7'd1, 1'b0, 1'b1),
			pinned_row(MODE_WRITE, 8'h5A, 7'd0, 8'h00, ST_DROPPED, 7'd1, 1'b0, 1'b1),
			pinned_row(MODE_READ, 8'h00, 7'd2, 8'h00, ST_REJECT, 7'd1, 1'b0, 1'b1),
			pinned_row(MODE_READ, 8'h00, 7'd1, 8'hA5, ST_READ, 7'd0, 1'b1, 1'b0),
			size_row(32'd3),
			word_row(MODE_WRITE, 8'h11, 7'd0),
			word_row(MODE_WRITE, 8'h22, 7'd0),
			pinned_row(MODE_WRITE, 8'h33, 7'd0, 8'h00, ST_WRITTEN, 7'd3, 1'b0, 1'b1),
			pinned_row(MODE_WRITE, 8'h44, 7'd0, 8'h00, ST_DROPPED, 7'd3, 1'b0, 1'b1),
			pinned_row(MODE_READ, 8'h00, 7'd4, 8'h00, ST_REJECT, 7'd3, 1'b0, 1'b1),
			word_row(MODE_READ, 8'h00, 7'd2),
			word_row(MODE_WRITE, 8'h55, 7'd0),
			word_row(MODE_WRITE, 8'h66, 7'd0),
			word_row(MODE_READ, 8'h00, 7'd3),
			pinned_row(MODE_READ, 8'h00, 7'd1, 8'h00, ST_EMPTY, 7'd0, 1'b1, 1'b0),
			size_row(32'd127),
			pinned_row(MODE_WRITE, 8'h80, 7'd0, 8'h00, ST_WRITTEN, 7'd1, 1'b0, 1'b0),
			word_row(MODE_READ, 8'h00, 7'd0)
		};

		phases = '{
			'{1, 25, 50, 1'b0, 1'b0},
			'{DEPTH, 20, 55, 1'b1, 1'b0},
			'{2, 25, 50, 1'b0, 1'b0},
			'{RANDOM_SIZE, 25, 55, 1'b0, 1'b0},
			'{5, 20, 50, 1'b1, 1'b0},
			'{DEPTH, 25, 50, 1'b0, 1'b1},
			'{RANDOM_SIZE, 25, 60, 1'b0, 1'b0},
			'{33, 20, 55, 1'b0, 1'b0}
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == DO_SIZE)
				set_ring_size(plan[i].size);
			else
				send_word(plan[i].mode, plan[i].wdata, plan[i].cnt, plan[i].pinned,
					plan[i].pin);
		end

		foreach (phases[p]) begin
			sz = (phases[p].size == RANDOM_SIZE) ? $urandom_range(DEPTH, 1) : phases[p].size;
			set_ring_size(sz);
			calm = phases[p].calm;
			// fill past full, then drain the whole ring in one burst
			if (phases[p].fill) begin
				repeat (sz + 2)
					send_word(MODE_WRITE, 8'($urandom_range(255)), '0, 1'b0, none);
				send_word(MODE_READ, '0, LEN_W'(sz), 1'b0, none);
			end
			repeat (phases[p].items) begin
				if ($urandom_range(99) < phases[p].write_pct)
					send_word(MODE_WRITE, 8'($urandom_range(255)), '0, 1'b0, none);
				else
					send_random_read(sz);
			end
			calm = 1'b0;
		end

		drain();
		repeat (5) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### files.f
rtl/brf_pkg.sv
rtl/brf_if.sv
rtl/brf_ctrl.sv
rtl/brf_datapath.sv
rtl/byte_ring_fifo.sv
sim/tb_byte_ring_fifo.sv
